/* hw/rtl/jac_pkg.sv */
// Shared constants and types for the joystick axis conditioner.
package jac_pkg;

  localparam int SampleMax = 4096;

  localparam int RegAddrW = 4;
  localparam logic [1:0] RegInvert     = 2'd0;
  localparam logic [1:0] RegDetentStep = 2'd1;
  localparam logic [1:0] RegDeadZone   = 2'd2;

  localparam logic OpSample    = 1'b0;
  localparam logic OpCalibrate = 1'b1;

  typedef struct packed {
    logic signed [13:0] press_level;
    logic signed [1:0]  rotate_step;
    logic signed [14:0] position_delta;
    logic signed [13:0] position;
  } result_t;

endpackage

/* hw/rtl/joystick_axis_conditioner_core.sv */
// Joystick axis conditioner: clamp, zero correction, delta, detent and dead zone.
// Takes one item per clock while the skid register is empty. All of the work is
// a single registered pass of adds and compares. A two-entry output buffer
// (result register plus skid register) takes one more item while a result
// waits on m_tready. Registers sit on an APB port at byte addresses 0 (invert),
// 4 (detent_step) and 8 (dead_zone).
module joystick_axis_conditioner_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,  // [12:0] adc_sample
  input  logic [1:0]                    s_tuser,  // [0] op, [1] read_ok
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [13:0] position, [28:14] position_delta, [30:29] rotate_step,
  // [44:31] press_level
  output logic [47:0]                   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jac_pkg::RegAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import jac_pkg::*;

  logic        invert;
  logic [12:0] detent_step;
  logic [12:0] dead_zone;

  logic [12:0]        zero_level;
  logic signed [13:0] last_position;
  logic signed [14:0] detent_anchor;

  result_t out_res, skid_res, res_next;
  logic    out_valid, skid_valid;

  logic        accept, pop, op, read_ok;
  logic [12:0] sample;
  logic [16:0] sample_wide;
  logic [13:0] diff;
  logic signed [13:0] pos;
  logic signed [16:0] pos_w, anchor_up, anchor_dn, dz_w;
  logic signed [14:0] anchor_next;
  logic signed [1:0]  step;
  logic signed [16:0] press_w;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert      <= 1'b0;
      detent_step <= 13'd1;
      dead_zone   <= 13'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        RegInvert:     invert      <= pwdata[0];
        RegDetentStep: detent_step <= pwdata[12:0];
        RegDeadZone:   dead_zone   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegInvert:     prdata = {31'd0, invert};
      RegDetentStep: prdata = {19'd0, detent_step};
      RegDeadZone:   prdata = {19'd0, dead_zone};
      default:       prdata = 32'd0;
    endcase
  end

  // datapath
  assign op      = s_tuser[0];
  assign read_ok = s_tuser[1];
  assign accept  = s_tvalid && s_tready;
  assign pop     = out_valid && m_tready;

  always_comb begin
    sample_wide = read_ok ? {4'd0, s_tdata[12:0]} : 17'd0;
    if (sample_wide > 17'(SampleMax)) begin
      sample_wide = 17'(SampleMax);
    end
    sample = sample_wide[12:0];

    diff = {1'b0, sample} - {1'b0, zero_level};
    pos  = invert ? $signed(-diff) : $signed(diff);

    pos_w     = 17'(pos);
    anchor_up = 17'(detent_anchor) + $signed({4'd0, detent_step});
    anchor_dn = 17'(detent_anchor) - $signed({4'd0, detent_step});
    if (pos_w >= anchor_up) begin
      anchor_next = anchor_up[14:0];
      step        = 2'sd1;
    end else if (pos_w <= anchor_dn) begin
      anchor_next = anchor_dn[14:0];
      step        = -2'sd1;
    end else begin
      anchor_next = detent_anchor;
      step        = 2'sd0;
    end

    dz_w = $signed({4'd0, dead_zone});
    if (pos_w >= dz_w) begin
      press_w = pos_w - dz_w + 17'sd1;
    end else if (pos_w <= -dz_w) begin
      press_w = pos_w + dz_w - 17'sd1;
    end else begin
      press_w = 17'sd0;
    end

    if (op == OpCalibrate) begin
      res_next = '0;
    end else begin
      res_next.position       = pos;
      res_next.position_delta = 15'(pos) - 15'(last_position);
      res_next.rotate_step    = step;
      res_next.press_level    = press_w[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_level    <= '0;
      last_position <= '0;
      detent_anchor <= '0;
    end else if (accept) begin
      if (op == OpCalibrate) begin
        zero_level    <= sample;
        last_position <= '0;
        detent_anchor <= '0;
      end else begin
        last_position <= pos;
        detent_anchor <= anchor_next;
      end
    end
  end

  // output register with skid stage
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_res <= skid_valid ? skid_res : res_next;
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res};

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without result entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready && accept |=> skid_valid)
    else $error("item accepted during stall was not buffered");

  a_cal_clears: assert property (@(posedge clk) disable iff (rst)
    accept && op == OpCalibrate |=> last_position == 14'sd0 && detent_anchor == 15'sd0)
    else $error("calibrate did not clear tracking state");

  a_step_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.rotate_step != 2'b10)
    else $error("bad rotate step code");

endmodule
